// ===== src/sbo_pkg.sv =====
// ----------------------------------------------------------------------------
// sbo_pkg: shared constants for the sprite blitter
// Register indexes, orientation codes and derived field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package sbo_pkg;

    localparam int MAX_DIM         = 1024;
    localparam int BYTES_PER_PIXEL = 2;

    // Widths that follow from the sprite size limit
    localparam int DIM_W = $clog2(MAX_DIM + 1);  // sprite_width / sprite_height
    localparam int CNT_W = $clog2(MAX_DIM);      // scan counters

    localparam int ORG_W   = 12;                 // dest_x / dest_y
    localparam int POS_W   = ((CNT_W > ORG_W) ? CNT_W : ORG_W) + 1;
    localparam int LL_W    = 14;
    localparam int COLOR_W = 16;
    localparam int ADDR_W  = 26;
    localparam int ORI_W   = 3;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_SPRITE_WIDTH  = 3'd0;
    localparam t_cfg_idx REG_SPRITE_HEIGHT = 3'd1;
    localparam t_cfg_idx REG_DEST_X        = 3'd2;
    localparam t_cfg_idx REG_DEST_Y        = 3'd3;
    localparam t_cfg_idx REG_ORIENTATION   = 3'd4;
    localparam t_cfg_idx REG_COLOR_KEY     = 3'd5;
    localparam t_cfg_idx REG_LINE_LENGTH   = 3'd6;

    typedef logic [ORI_W-1:0] t_ori;

    localparam t_ori ORI_MIRROR_X    = 3'b111;  // -1
    localparam t_ori ORI_NORMAL      = 3'b000;
    localparam t_ori ORI_XPOSE_FLIPY = 3'b001;
    localparam t_ori ORI_ROT180      = 3'b010;
    localparam t_ori ORI_XPOSE_FLIPX = 3'b011;

    localparam logic [LL_W-1:0] LINE_LENGTH_RESET = 14'd2560;

endpackage

`default_nettype wire

// ===== src/sprite_blit_with_orientation.sv =====
// ----------------------------------------------------------------------------
// sprite_blit_with_orientation: sprite blitter with orientation and color key
// Maps each source pixel to a framebuffer write address and write enable.
// ----------------------------------------------------------------------------
// Throughput: 1 word per cycle while the output is not stalled by i_ready;
//   accepted words pass the position/mirror stage and then the
//   address multiply-add stage, which each hold one word.
// Reset: synchronous active-low; configuration registers return to their defaults,
//   scan counters go to row 0, column 0, pipeline empties.
`default_nettype none

module sprite_blit_with_orientation
    import sbo_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,

    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [COLOR_W-1:0]    i_pixel_color,

    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic                       o_write_enable,
    output logic [ADDR_W-1:0]          o_byte_address,
    output logic [COLOR_W-1:0]         o_write_color,
    output logic                       o_sprite_done
);

    // Configuration registers
    logic [DIM_W-1:0] r_width, r_height;
    logic [ORG_W-1:0] r_dest_x, r_dest_y;
    t_ori             r_ori;
    logic             r_key_en;
    logic [LL_W-1:0]  r_line_len;

    // Scan counters
    logic [CNT_W-1:0] r_col, r_row, n_col, n_row;

    // Stage 1: position
    logic               r_s1_valid;
    logic [POS_W-1:0]   r_s1_px, r_s1_py;
    logic [COLOR_W-1:0] r_s1_color;
    logic               r_s1_we, r_s1_done;

    // Stage 2: result
    logic               r_o_valid;
    logic [ADDR_W-1:0]  r_o_addr;
    logic [COLOR_W-1:0] r_o_color;
    logic               r_o_we, r_o_done;

    logic cfg_we, in_acc, s1_adv, size_we;
    logic [CNT_W-1:0] w_m1, h_m1, c_eff, r_eff, x_off, y_off;
    logic [POS_W-1:0] n_px, n_py;
    logic [POS_W+LL_W-1:0] row_prod;
    logic [ADDR_W-1:0] n_addr;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid;
    assign size_we     = cfg_we && (i_cfg_index == REG_SPRITE_WIDTH ||
                                    i_cfg_index == REG_SPRITE_HEIGHT);

    assign s1_adv  = !r_o_valid || i_ready;
    assign o_ready = !r_s1_valid || s1_adv;
    assign in_acc  = i_valid && o_ready;

    // Effective size minus one: 0 acts as 1, above the limit acts as the limit
    always_comb begin
        if (r_width == '0) begin
            w_m1 = '0;
        end else if (r_width > DIM_W'(MAX_DIM)) begin
            w_m1 = CNT_W'(MAX_DIM - 1);
        end else begin
            w_m1 = CNT_W'(r_width - DIM_W'(1));
        end
        if (r_height == '0) begin
            h_m1 = '0;
        end else if (r_height > DIM_W'(MAX_DIM)) begin
            h_m1 = CNT_W'(MAX_DIM - 1);
        end else begin
            h_m1 = CNT_W'(r_height - DIM_W'(1));
        end
    end

    always_comb begin
        c_eff = (r_col > w_m1) ? w_m1 : r_col;
        r_eff = (r_row > h_m1) ? h_m1 : r_row;

        if (c_eff == w_m1) begin
            n_col = '0;
            n_row = (r_eff == h_m1) ? '0 : r_eff + CNT_W'(1);
        end else begin
            n_col = c_eff + CNT_W'(1);
            n_row = r_eff;
        end

        case (r_ori)
            ORI_MIRROR_X: begin
                x_off = w_m1 - c_eff;
                y_off = r_eff;
            end
            ORI_NORMAL: begin
                x_off = c_eff;
                y_off = r_eff;
            end
            ORI_XPOSE_FLIPY: begin
                x_off = h_m1 - r_eff;
                y_off = c_eff;
            end
            ORI_ROT180: begin
                x_off = w_m1 - c_eff;
                y_off = h_m1 - r_eff;
            end
            default: begin  // transpose flip x, also the unlisted codes
                x_off = r_eff;
                y_off = w_m1 - c_eff;
            end
        endcase

        n_px = POS_W'(x_off) + POS_W'(r_dest_x);
        n_py = POS_W'(y_off) + POS_W'(r_dest_y);
    end

    always_comb begin
        row_prod = r_s1_py * r_line_len;
        n_addr   = ADDR_W'(r_s1_px) * ADDR_W'(BYTES_PER_PIXEL) + row_prod[ADDR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= DIM_W'(1);
            r_height   <= DIM_W'(1);
            r_dest_x   <= '0;
            r_dest_y   <= '0;
            r_ori      <= ORI_NORMAL;
            r_key_en   <= 1'b0;
            r_line_len <= LINE_LENGTH_RESET;
            r_col      <= '0;
            r_row      <= '0;
        end else begin
            // a size write restarts the scan
            if (size_we) begin
                r_col <= '0;
                r_row <= '0;
            end else if (in_acc) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (cfg_we) begin
                case (i_cfg_index)
                    REG_SPRITE_WIDTH:  r_width    <= i_cfg_data[DIM_W-1:0];
                    REG_SPRITE_HEIGHT: r_height   <= i_cfg_data[DIM_W-1:0];
                    REG_DEST_X:        r_dest_x   <= i_cfg_data[ORG_W-1:0];
                    REG_DEST_Y:        r_dest_y   <= i_cfg_data[ORG_W-1:0];
                    REG_ORIENTATION:   r_ori      <= i_cfg_data[ORI_W-1:0];
                    REG_COLOR_KEY:     r_key_en   <= i_cfg_data[0];
                    REG_LINE_LENGTH:   r_line_len <= i_cfg_data[LL_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (o_ready) begin
                r_s1_valid <= i_valid;
            end
            if (s1_adv) begin
                r_o_valid <= r_s1_valid;
            end
        end
    end

    // Pipeline payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_px    <= n_px;
            r_s1_py    <= n_py;
            r_s1_color <= i_pixel_color;
            r_s1_we    <= !(r_key_en && (i_pixel_color == '0));
            r_s1_done  <= (c_eff == w_m1) && (r_eff == h_m1);
        end
        if (s1_adv && r_s1_valid) begin
            r_o_addr  <= n_addr;
            r_o_color <= r_s1_color;
            r_o_we    <= r_s1_we;
            r_o_done  <= r_s1_done;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_write_enable = r_o_we;
    assign o_byte_address = r_o_addr;
    assign o_write_color  = r_o_color;
    assign o_sprite_done  = r_o_done;

`ifndef ASSERT_OFF
    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col <= w_m1) && (r_row <= h_m1))
        else $error("scan counter beyond sprite size");

    a_size_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_we && (i_cfg_index == REG_SPRITE_WIDTH || i_cfg_index == REG_SPRITE_HEIGHT)
        |=> (r_col == '0) && (r_row == '0))
        else $error("size write did not restart scan");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_adv |=> r_s1_valid && $stable(r_s1_px) && $stable(r_s1_py))
        else $error("stage 1 word lost under stall");

    a_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !cfg_we && (c_eff == w_m1) && (r_eff == h_m1)
        |=> (r_col == '0) && (r_row == '0))
        else $error("scan did not wrap after last pixel");
`endif

endmodule

`default_nettype wire
